FILE: rtl/core/audio_buffer_ring_manager_top_assert.svh
// ------------------------------------------------------------------------
// audio buffer ring manager assertion macros
// shared property wrappers for the ring manager checks
// ------------------------------------------------------------------------
`ifndef AUDIO_BUFFER_RING_MANAGER_TOP_ASSERT_SVH
`define AUDIO_BUFFER_RING_MANAGER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ABRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("abrm check failed: same-cycle rule");

// next-cycle implication, checked out of reset
`define ABRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("abrm check failed: next-cycle rule");

`endif

FILE: rtl/core/abrm_pkg.sv
// ------------------------------------------------------------------------
// abrm_pkg
// types and codes shared by the audio buffer ring manager modules
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package abrm_pkg;

    // request kinds carried in the input tuser
    typedef enum logic [1:0] {
        ACT_SUBMIT    = 2'd0,
        ACT_WAIT      = 2'd1,
        ACT_DMA_DONE  = 2'd2,
        ACT_CLEAR     = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INVALID    = 2'd1,
        ST_RING_FULL  = 2'd2,
        ST_WAITER     = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic [1:0] CFG_RING_VALID   = 2'd0;
    localparam logic [1:0] CFG_BUFFER_COUNT = 2'd1;
    localparam logic [1:0] CFG_BUFFER_BYTES = 2'd2;
    localparam logic [1:0] CFG_BASE_ADDRESS = 2'd3;

    // configuration reset values
    localparam logic        RST_RING_VALID   = 1'b0;
    localparam logic [6:0]  RST_BUFFER_COUNT = 7'd2;
    localparam logic [15:0] RST_BUFFER_BYTES = 16'd512;
    localparam logic [31:0] RST_BASE_ADDRESS = 32'd0;

    // ring configuration as seen by the controller
    typedef struct packed {
        logic        ring_valid;
        logic [6:0]  buffer_count;
        logic [15:0] buffer_bytes;
        logic [31:0] base_address;
    } t_ring_cfg;

    // one request item
    typedef struct packed {
        t_action action;
        logic    has_filled;
        logic    wants_next;
    } t_req;

    // one result item
    typedef struct packed {
        t_status     status;
        logic [31:0] buffer_address;
        logic        is_silence;
        logic        wake_waiter;
    } t_result;

endpackage

FILE: rtl/core/abrm_ring_ctrl.sv
// ------------------------------------------------------------------------
// abrm_ring_ctrl
// ring index state and the per-item update, address and status logic
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module abrm_ring_ctrl #(
    parameter int MAX_BUFFERS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  abrm_pkg::t_req     i_req,
    input  abrm_pkg::t_ring_cfg i_cfg,
    output abrm_pkg::t_result  o_res
);

    localparam int IDX_W = $clog2(MAX_BUFFERS);
    localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
    localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;
    localparam int PRD_W = CNT_W + 16;

    logic [IDX_W-1:0] r_dma_index;
    logic [IDX_W-1:0] r_fill_index;
    logic [IDX_W-1:0] r_ready_index;
    logic             r_waiter_pending;

    logic [IDX_W-1:0] n_dma_index;
    logic [IDX_W-1:0] n_fill_index;
    logic [IDX_W-1:0] n_ready_index;
    logic             n_waiter_pending;

    logic [CMP_W-1:0] w_cnt_ext;
    logic [CNT_W-1:0] w_eff;
    logic [IDX_W-1:0] w_fill_inc;
    logic             w_full;
    logic [CNT_W-1:0] w_mul_op;
    logic [PRD_W-1:0] w_prod;
    logic             w_use_addr;
    abrm_pkg::t_status w_status;
    logic             w_silence;
    logic             w_wake;

    // increment with wrap at the effective count
    function automatic logic [IDX_W-1:0] f_wrap(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] eff);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + CNT_W'(1);
        return (nxt >= eff) ? '0 : nxt[IDX_W-1:0];
    endfunction

    // effective count saturated into two up to the ring depth
    always_comb begin
        w_cnt_ext = CMP_W'(i_cfg.buffer_count);
        if (w_cnt_ext < CMP_W'(2)) begin
            w_eff = CNT_W'(2);
        end else if (w_cnt_ext > CMP_W'(MAX_BUFFERS)) begin
            w_eff = CNT_W'(MAX_BUFFERS);
        end else begin
            w_eff = w_cnt_ext[CNT_W-1:0];
        end
    end

    // full when the producer would run into the dma position
    assign w_fill_inc = f_wrap(r_fill_index, w_eff);
    assign w_full     = (w_fill_inc == r_dma_index);

    // next state and result selection
    always_comb begin
        n_dma_index      = r_dma_index;
        n_fill_index     = r_fill_index;
        n_ready_index    = r_ready_index;
        n_waiter_pending = r_waiter_pending;
        w_status         = abrm_pkg::ST_OK;
        w_use_addr       = 1'b0;
        w_mul_op         = CNT_W'(r_fill_index);
        w_silence        = 1'b0;
        w_wake           = 1'b0;

        if (i_req.action == abrm_pkg::ACT_CLEAR) begin
            n_dma_index   = '0;
            n_fill_index  = '0;
            n_ready_index = '0;
        end else if (!i_cfg.ring_valid) begin
            w_status = abrm_pkg::ST_INVALID;
        end else begin
            case (i_req.action)
                abrm_pkg::ACT_SUBMIT: begin
                    if (i_req.has_filled && !i_req.wants_next) begin
                        w_status = abrm_pkg::ST_INVALID;
                    end else begin
                        if (i_req.has_filled) begin
                            n_ready_index = f_wrap(r_ready_index, w_eff);
                        end
                        if (i_req.wants_next) begin
                            if (w_full) begin
                                w_status = abrm_pkg::ST_RING_FULL;
                            end else begin
                                w_use_addr   = 1'b1;
                                n_fill_index = w_fill_inc;
                            end
                        end
                    end
                end
                abrm_pkg::ACT_WAIT: begin
                    if (w_full) begin
                        n_waiter_pending = 1'b1;
                        w_status         = abrm_pkg::ST_WAITER;
                    end else begin
                        n_waiter_pending = 1'b0;
                    end
                end
                abrm_pkg::ACT_DMA_DONE: begin
                    w_use_addr = 1'b1;
                    if (r_ready_index != r_dma_index) begin
                        w_mul_op    = CNT_W'(r_dma_index);
                        n_dma_index = f_wrap(r_dma_index, w_eff);
                    end else begin
                        // nothing queued: silence buffer sits just past the ring
                        w_mul_op  = w_eff;
                        w_silence = 1'b1;
                    end
                    if (r_waiter_pending && (w_fill_inc != n_dma_index)) begin
                        n_waiter_pending = 1'b0;
                        w_wake           = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // one shared multiply-add for every handed-out address
    assign w_prod = PRD_W'(w_mul_op) * PRD_W'(i_cfg.buffer_bytes);

    always_comb begin
        o_res.status         = w_status;
        o_res.buffer_address = w_use_addr ? (i_cfg.base_address + 32'(w_prod)) : 32'd0;
        o_res.is_silence     = w_silence;
        o_res.wake_waiter    = w_wake;
    end

    // index state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dma_index      <= '0;
            r_fill_index     <= '0;
            r_ready_index    <= '0;
            r_waiter_pending <= 1'b0;
        end else if (i_step) begin
            r_dma_index      <= n_dma_index;
            r_fill_index     <= n_fill_index;
            r_ready_index    <= n_ready_index;
            r_waiter_pending <= n_waiter_pending;
        end
    end

endmodule

FILE: rtl/core/audio_buffer_ring_manager_top.sv
// ------------------------------------------------------------------------
// audio_buffer_ring_manager_top
// three-index playback buffer ring with stream request and result ports
// ------------------------------------------------------------------------
// The block takes one request item per clock while results are taken and
// returns exactly one result item for each, in order. An item accepted at
// a clock edge sits in the input register; the index update and the single
// index-times-size multiply-add load its result into the result register
// once that register is empty or being read. Throughput is one item per cycle
// while the receiver takes results; the result and input registers let the
// next item enter while a result waits to be taken. Configuration writes are
// always accepted and must be issued only while no item is in flight.
`timescale 1ns / 1ps

`include "audio_buffer_ring_manager_top_assert.svh"

module audio_buffer_ring_manager_top #(
    parameter int MAX_BUFFERS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] has_filled, [1] wants_next, [7:2] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] action

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [1:0] status, [33:2] buffer_address,
                                        // [34] wake_waiter, [39:35] zero
    output logic        m_axis_tuser,   // [0] is_silence

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    logic        r_ring_valid;
    logic [6:0]  r_buffer_count;
    logic [15:0] r_buffer_bytes;
    logic [31:0] r_base_address;

    logic                r_in_valid;
    abrm_pkg::t_req      r_in_req;
    logic                r_out_valid;
    abrm_pkg::t_result   r_out;

    logic                n_in_valid;
    logic                n_out_valid;
    logic                w_adv;
    logic                w_step;
    logic                w_in_fire;
    abrm_pkg::t_ring_cfg w_cfg;
    abrm_pkg::t_result   w_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_valid   <= abrm_pkg::RST_RING_VALID;
            r_buffer_count <= abrm_pkg::RST_BUFFER_COUNT;
            r_buffer_bytes <= abrm_pkg::RST_BUFFER_BYTES;
            r_base_address <= abrm_pkg::RST_BASE_ADDRESS;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                abrm_pkg::CFG_RING_VALID:   r_ring_valid   <= i_cfg_data[0];
                abrm_pkg::CFG_BUFFER_COUNT: r_buffer_count <= i_cfg_data[6:0];
                abrm_pkg::CFG_BUFFER_BYTES: r_buffer_bytes <= i_cfg_data[15:0];
                abrm_pkg::CFG_BASE_ADDRESS: r_base_address <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.ring_valid   = r_ring_valid;
        w_cfg.buffer_count = r_buffer_count;
        w_cfg.buffer_bytes = r_buffer_bytes;
        w_cfg.base_address = r_base_address;
    end

    // pipeline flow control
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_step        = r_in_valid && w_adv;

    always_comb begin
        n_in_valid  = w_in_fire ? 1'b1 : (w_step ? 1'b0 : r_in_valid);
        n_out_valid = w_adv ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input item register
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_req.action     <= abrm_pkg::t_action'(s_axis_tuser);
            r_in_req.has_filled <= s_axis_tdata[0];
            r_in_req.wants_next <= s_axis_tdata[1];
        end
    end

    // ring state and per-item logic
    abrm_ring_ctrl #(
        .MAX_BUFFERS (MAX_BUFFERS)
    ) u_ring_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (r_in_req),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.wake_waiter, r_out.buffer_address, r_out.status};
    assign m_axis_tuser  = r_out.is_silence;

    // checks
    `ABRM_ASSERT_NOW(a_err_result_empty, i_clk, i_rst_n,
        r_out_valid && (r_out.status != abrm_pkg::ST_OK),
        (r_out.buffer_address == 32'd0) && !r_out.is_silence && !r_out.wake_waiter)
    `ABRM_ASSERT_NOW(a_silence_is_ok, i_clk, i_rst_n,
        r_out_valid && r_out.is_silence, r_out.status == abrm_pkg::ST_OK)
    `ABRM_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n,
        r_in_valid && !w_adv, !s_axis_tready)
    `ABRM_ASSERT_NEXT(a_stalled_result_kept, i_clk, i_rst_n,
        r_out_valid && !m_axis_tready, r_out_valid && $stable(r_out))

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_top
// stream-level test of the audio buffer ring manager: requests are sent
// with random gaps, a behavioral copy of the ring predicts every result,
// and each result item is compared in order while the receiver stalls at
// random; ring settings change between phases while the block is idle
// ------------------------------------------------------------------------

module tb_top;
    import abrm_pkg::*;

    localparam int RING_MAX = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [0] has_filled, [1] wants_next, [7:2] zero
    logic [1:0]  s_axis_tuser;    // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [1:0] status, [33:2] buffer_address,
                                  // [34] wake_waiter, [39:35] zero
    logic        m_axis_tuser;    // [0] is_silence
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;

    audio_buffer_ring_manager_top #(
        .MAX_BUFFERS(RING_MAX)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow ring settings and indices
    logic        ring_on    = RST_RING_VALID;
    logic [6:0]  ring_count = RST_BUFFER_COUNT;
    logic [15:0] ring_bytes = RST_BUFFER_BYTES;
    logic [31:0] ring_base  = RST_BASE_ADDRESS;
    int          dma_idx    = 0;
    int          fill_idx   = 0;
    int          ready_idx  = 0;
    logic        waiter     = 1'b0;

    t_result expected_results[$];

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int settings_used = 0;
    int full_hits     = 0;
    int waiter_hits   = 0;
    int silence_hits  = 0;
    int wake_hits     = 0;
    int sink_hold     = 0;
    bit quiet         = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time,
                 expected_results.size());
        $display("tb_top failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ring size after saturation into the legal range
    function automatic int ring_size();
        int c;
        c = int'(ring_count);
        if (c < 2) c = 2;
        if (c > RING_MAX) c = RING_MAX;
        return c;
    endfunction

    function automatic int bump(int idx);
        return (idx + 1 >= ring_size()) ? 0 : idx + 1;
    endfunction

    function automatic logic [31:0] slot_address(int idx);
        return ring_base + 32'(idx) * 32'(ring_bytes);
    endfunction

    function automatic logic ring_full();
        return bump(fill_idx) == dma_idx;
    endfunction

    // advance the shadow ring by one request and return its result
    function automatic t_result ring_step(t_action act, logic hf, logic wn);
        t_result r;
        r = '0;
        r.status = ST_OK;
        if (act == ACT_CLEAR) begin
            dma_idx   = 0;
            fill_idx  = 0;
            ready_idx = 0;
        end else if (!ring_on) begin
            r.status = ST_INVALID;
        end else begin
            case (act)
                ACT_SUBMIT: begin
                    if (hf && !wn) begin
                        r.status = ST_INVALID;
                    end else begin
                        // ready mark sticks even when the ring turns out full
                        if (hf) ready_idx = bump(ready_idx);
                        if (wn) begin
                            if (ring_full()) begin
                                r.status = ST_RING_FULL;
                            end else begin
                                r.buffer_address = slot_address(fill_idx);
                                fill_idx = bump(fill_idx);
                            end
                        end
                    end
                end
                ACT_WAIT: begin
                    if (ring_full()) begin
                        waiter   = 1'b1;
                        r.status = ST_WAITER;
                    end else begin
                        waiter = 1'b0;
                    end
                end
                default: begin
                    if (ready_idx != dma_idx) begin
                        r.buffer_address = slot_address(dma_idx);
                        dma_idx = bump(dma_idx);
                    end else begin
                        // silence buffer sits right after the ring
                        r.buffer_address = ring_base + 32'(ring_bytes) * 32'(ring_size());
                        r.is_silence = 1'b1;
                    end
                    if (waiter && !ring_full()) begin
                        waiter = 1'b0;
                        r.wake_waiter = 1'b1;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // track register writes and predict each accepted request
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_RING_VALID:   ring_on    = i_cfg_data[0];
                    CFG_BUFFER_COUNT: ring_count = i_cfg_data[6:0];
                    CFG_BUFFER_BYTES: ring_bytes = i_cfg_data[15:0];
                    CFG_BASE_ADDRESS: ring_base  = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r = ring_step(t_action'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[1]);
                if (r.status == ST_RING_FULL) full_hits++;
                if (r.status == ST_WAITER) waiter_hits++;
                if (r.is_silence) silence_hits++;
                if (r.wake_waiter) wake_hits++;
                expected_results.push_back(r);
            end
        end
    end

    // compare each result item with the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got.status         = t_status'(m_axis_tdata[1:0]);
            got.buffer_address = m_axis_tdata[33:2];
            got.wake_waiter    = m_axis_tdata[34];
            got.is_silence     = m_axis_tuser;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status=%0d addr=%h sil=%b wake=%b",
                         $time, got.status, got.buffer_address, got.is_silence,
                         got.wake_waiter);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: expected status=%0d addr=%h sil=%b wake=%b", $time,
                             want.status, want.buffer_address, want.is_silence,
                             want.wake_waiter);
                    $display("%0t:   actual status=%0d addr=%h sil=%b wake=%b", $time,
                             got.status, got.buffer_address, got.is_silence,
                             got.wake_waiter);
                end
            end
        end
    end

    // result receiver: random stalls, quiet stretches and long hold-offs
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end else if (quiet || stall_left == 0) begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end else begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    // offer one request item and hold it until accepted
    task automatic send_item(input t_action act, input logic hf, input logic wn);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'd0, wn, hf};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // stop offering and wait for every result to come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (results_seen < items_sent) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // program all four registers back to back, block must be idle
    task automatic set_ring(input logic on, input logic [6:0] count,
                            input logic [15:0] bytes, input logic [31:0] base);
        write_reg(CFG_RING_VALID, {31'd0, on});
        write_reg(CFG_BUFFER_COUNT, {25'd0, count});
        write_reg(CFG_BUFFER_BYTES, {16'd0, bytes});
        write_reg(CFG_BASE_ADDRESS, base);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // weighted request: producer/consumer mix set by submit_pct
    task automatic send_random_item(input int submit_pct);
        int r;
        t_action act;
        logic hf;
        logic wn;
        r  = $urandom_range(0, 99);
        hf = 1'($urandom_range(0, 1));
        wn = 1'($urandom_range(0, 1));
        if (r < 2) act = ACT_CLEAR;
        else if (r < 12) act = ACT_WAIT;
        else if ($urandom_range(0, 99) < submit_pct) act = ACT_SUBMIT;
        else act = ACT_DMA_DONE;
        if (act == ACT_SUBMIT) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                hf = 1'b1;
                wn = 1'b1;
            end else if (r == 7) begin
                hf = 1'b0;
                wn = 1'b1;
            end
        end
        send_item(act, hf, wn);
    endtask

    task automatic run_phase(input int n, input int submit_pct);
        for (int i = 0; i < n; i++) send_random_item(submit_pct);
        drain();
    endtask

    // random ring settings, leaning to small rings and extreme values
    task automatic random_setting();
        logic [6:0]  count;
        logic [15:0] bytes;
        logic [31:0] base;
        case ($urandom_range(0, 5))
            0:       count = 7'($urandom_range(0, 1));
            1:       count = 7'($urandom_range(65, 127));
            2:       count = 7'd64;
            default: count = 7'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 5))
            0:       bytes = 16'd0;
            1:       bytes = 16'hFFFF;
            2:       bytes = 16'd32768;
            3:       bytes = 16'd1;
            default: bytes = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       base = 32'd0;
            1:       base = 32'hFFFF_FFFF;
            default: base = $urandom;
        endcase
        set_ring($urandom_range(0, 9) != 0, count, bytes, base);
    endtask

    // every request kind with no ring memory, then clear
    task automatic test_ring_disabled();
        send_item(ACT_SUBMIT, 1'b1, 1'b1);
        send_item(ACT_SUBMIT, 1'b0, 1'b1);
        send_item(ACT_WAIT, 1'b0, 1'b0);
        send_item(ACT_DMA_DONE, 1'b1, 1'b0);
        send_item(ACT_CLEAR, 1'b0, 1'b0);
        drain();
    endtask

    // walk a three-buffer ring through full, waiter, wake and silence
    task automatic test_ring_walk();
        set_ring(1'b1, 7'd3, 16'h0100, 32'hFFFF_FF00);
        send_item(ACT_SUBMIT, 1'b0, 1'b0);      // nothing asked
        send_item(ACT_SUBMIT, 1'b1, 1'b0);      // filled without request
        send_item(ACT_SUBMIT, 1'b0, 1'b1);
        send_item(ACT_WAIT, 1'b0, 1'b0);        // space left, no waiter
        send_item(ACT_SUBMIT, 1'b1, 1'b1);
        send_item(ACT_SUBMIT, 1'b1, 1'b1);      // full, ready mark kept
        send_item(ACT_WAIT, 1'b0, 1'b0);        // waiter registered
        send_item(ACT_DMA_DONE, 1'b0, 1'b0);    // wakes the waiter
        send_item(ACT_DMA_DONE, 1'b0, 1'b0);
        send_item(ACT_DMA_DONE, 1'b0, 1'b0);    // nothing ready, silence
        send_item(ACT_WAIT, 1'b0, 1'b0);
        send_item(ACT_CLEAR, 1'b1, 1'b1);
        send_item(ACT_DMA_DONE, 1'b1, 1'b1);
        drain();
    endtask

    // lower the count below the live indices, then keep going
    task automatic test_shrink_ring();
        set_ring(1'b1, 7'd8, 16'd0, 32'h0000_1000);
        for (int i = 0; i < 6; i++) send_item(ACT_SUBMIT, 1'b1, 1'b1);
        drain();
        set_ring(1'b1, 7'd4, 16'd48, 32'h0000_1000);
        send_item(ACT_SUBMIT, 1'b0, 1'b1);
        send_item(ACT_DMA_DONE, 1'b0, 1'b0);
        send_item(ACT_SUBMIT, 1'b1, 1'b1);
        drain();
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        quiet     = 1'b1;
        sink_hold = 150;
        for (int i = 0; i < 40; i++) send_random_item(60);
        drain();
        quiet = 1'b0;
    endtask

    // random phases over extreme and random ring settings
    task automatic test_random_phases();
        set_ring(1'b1, 7'd127, 16'hFFFF, 32'hFFFF_FFFF);
        run_phase(110, 55);
        set_ring(1'b1, 7'd0, 16'd0, 32'h8000_0000);
        run_phase(110, 60);
        set_ring(1'b1, 7'd64, 16'd32768, 32'd0);
        run_phase(160, 90);
        for (int p = 0; p < 11; p++) begin
            random_setting();
            quiet = (p == 4);
            run_phase(110, $urandom_range(30, 85));
        end
        quiet = 1'b0;
    endtask

    // test sequence
    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_SUBMIT;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= CFG_RING_VALID;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ring_disabled();
        test_ring_walk();
        test_shrink_ring();
        test_backpressure();
        test_random_phases();

        // settle past the result latency
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end
        $display("ran %0d requests under %0d ring settings, %0d results checked",
                 items_sent, settings_used, results_seen);
        $display("ring full %0d, waiters %0d, silence %0d, wakes %0d",
                 full_hits, waiter_hits, silence_hits, wake_hits);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

FILE: audio_buffer_ring_manager_top.f
+incdir+rtl/core
rtl/core/abrm_pkg.sv
rtl/core/abrm_ring_ctrl.sv
rtl/core/audio_buffer_ring_manager_top.sv
tb/sv/tb_top.sv
